// File: src/dll_pkg.sv
package dll_pkg;

  localparam int Capacity   = 64;
  localparam int KeyBits    = 32;
  localparam int SlotBits   = $clog2(Capacity);
  localparam int CntBits    = $clog2(Capacity + 1);
  localparam int KindBits   = 3;
  localparam int StatusBits = 2;
  localparam int PortKeyBits = 32;

  typedef logic [SlotBits-1:0]        slot_t;
  typedef logic [CntBits-1:0]         cnt_t;
  typedef logic signed [KeyBits-1:0]  key_t;

  typedef enum logic [KindBits-1:0] {
    KindInsert   = 3'd0,
    KindDelKey   = 3'd1,
    KindDelFirst = 3'd2,
    KindDelLast  = 3'd3,
    KindDump     = 3'd4
  } kind_e;

  typedef enum logic [StatusBits-1:0] {
    StatDone = 2'd0,
    StatFull = 2'd1,
    StatNone = 2'd2,
    StatElem = 2'd3
  } status_e;

  typedef struct packed {
    logic [KindBits-1:0]           kind;
    logic signed [PortKeyBits-1:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic [StatusBits-1:0]         status;
    logic signed [PortKeyBits-1:0] key_out;
    logic                          last;
  } out_item_t;

  // write side of the link store, one write port per array
  typedef struct packed {
    logic  key_we;
    slot_t key_addr;
    key_t  key_data;
    logic  next_we;
    slot_t next_addr;
    slot_t next_data;
    logic  prev_we;
    slot_t prev_addr;
    slot_t prev_data;
  } store_wr_t;

  typedef struct packed {
    key_t  key;
    slot_t next;
    slot_t prev;
  } store_rd_t;

endpackage

// File: src/doubly_linked_list_engine.sv
// Bounded doubly linked list of up to 64 signed keys held in a slot store with a free-slot
// stack. Each input item is one operation (insert front, delete by key, delete first,
// delete last, dump); every operation but dump answers with one status item, a dump sends
// one item per element front to back with last set on the final one (an empty dump sends
// one empty status), and kinds 5 to 7 are dropped silently. Only one item is worked on at a
// time and the input is ready only while the sequencer is idle; an item may be accepted
// while the previous result still waits on the output. The link store has a single read
// port with registered data, so list walks visit one element per cycle, and a dump walk
// holds while the output is stalled. Insert writes the new slot and then links it in
// front. The link store needs no clearing pass after reset.
module doubly_linked_list_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dll_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dll_pkg::out_item_t out_o
);
  import dll_pkg::*;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StIns     = 7'b0000010,
    StInsLink = 7'b0000100,
    StSearch  = 7'b0001000,
    StUnlink  = 7'b0010000,
    StDump    = 7'b0100000,
    StResp    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  slot_t  head_q, head_d, tail_q, tail_d;
  cnt_t   count_q, count_d;
  cnt_t   free_count_q, free_count_d;
  cnt_t   low_mark_q, low_mark_d;
  cnt_t   idx_q, idx_d;
  slot_t  cur_q, cur_d;
  key_t   key_q, key_d;
  logic [StatusBits-1:0] res_q, res_d;

  out_item_t out_q;
  logic      out_valid_q;
  out_item_t emit_item;
  logic      emit;
  logic      out_free;

  store_wr_t wr;
  store_rd_t rd;
  slot_t     rd_addr;

  // free-slot stack; positions below the low mark were never written and hold their index
  slot_t free_mem [Capacity];
  slot_t fs_rdata_q;
  slot_t fs_raddr;
  logic  fs_we;
  slot_t fs_waddr;
  slot_t fs_wdata;

  cnt_t  top_idx;
  cnt_t  idx_inc;
  slot_t ins_slot;
  logic  key_match;

  dll_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (rd_addr),
    .rd_o    (rd)
  );

  always_ff @(posedge clk_i) begin
    if (fs_we) free_mem[fs_waddr] <= fs_wdata;
    fs_rdata_q <= free_mem[fs_raddr];
  end

  assign top_idx   = free_count_q - cnt_t'(1);
  assign idx_inc   = idx_q + cnt_t'(1);
  assign ins_slot  = (top_idx < low_mark_q) ? top_idx[SlotBits-1:0] : fs_rdata_q;
  assign key_match = (rd.key == key_q);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    free_count_d = free_count_q;
    low_mark_d   = low_mark_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    key_d        = key_q;
    res_d        = res_q;
    wr           = '0;
    rd_addr      = cur_q;
    fs_raddr     = top_idx[SlotBits-1:0];
    fs_we        = 1'b0;
    fs_waddr     = free_count_q[SlotBits-1:0];
    fs_wdata     = cur_q;
    emit         = 1'b0;
    emit_item    = '0;
    in_ready_o   = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        rd_addr    = (kind_e'(in_i.kind) == KindDelLast) ? tail_q : head_q;
        if (in_valid_i) begin
          key_d = KeyBits'(in_i.key_in);
          cur_d = rd_addr;
          idx_d = '0;
          unique case (kind_e'(in_i.kind))
            KindInsert: begin
              if (free_count_q == '0 || count_q >= cnt_t'(Capacity)) begin
                res_d   = StatFull;
                state_d = StResp;
              end else begin
                state_d = StIns;
              end
            end
            KindDelKey, KindDelFirst, KindDelLast, KindDump: begin
              if (count_q == '0) begin
                res_d   = StatNone;
                state_d = StResp;
              end else begin
                unique case (kind_e'(in_i.kind))
                  KindDelKey: state_d = StSearch;
                  KindDump:   state_d = StDump;
                  default:    state_d = StUnlink;
                endcase
              end
            end
            default: state_d = StIdle;
          endcase
        end
      end

      StIns: begin
        wr.key_we    = 1'b1;
        wr.key_addr  = ins_slot;
        wr.key_data  = key_q;
        wr.next_we   = 1'b1;
        wr.next_addr = ins_slot;
        wr.next_data = (count_q == '0) ? '0 : head_q;
        wr.prev_we   = 1'b1;
        wr.prev_addr = ins_slot;
        wr.prev_data = '0;
        cur_d        = ins_slot;
        state_d      = StInsLink;
      end

      StInsLink: begin
        if (count_q != '0) begin
          wr.prev_we   = 1'b1;
          wr.prev_addr = head_q;
          wr.prev_data = cur_q;
        end else begin
          tail_d = cur_q;
        end
        head_d       = cur_q;
        count_d      = count_q + cnt_t'(1);
        free_count_d = top_idx;
        if (top_idx < low_mark_q) low_mark_d = top_idx;
        res_d   = StatDone;
        state_d = StResp;
      end

      StSearch, StUnlink: begin
        if (state_q == StUnlink || key_match) begin
          // unlink cur_q using its own next and prev links
          if (cur_q == head_q) begin
            head_d = rd.next;
          end else begin
            wr.next_we   = 1'b1;
            wr.next_addr = rd.prev;
            wr.next_data = rd.next;
          end
          if (cur_q == tail_q) begin
            tail_d = rd.prev;
          end else begin
            wr.prev_we   = 1'b1;
            wr.prev_addr = rd.next;
            wr.prev_data = rd.prev;
          end
          if (count_q != '0) count_d = count_q - cnt_t'(1);
          if (count_d == '0) begin
            head_d = '0;
            tail_d = '0;
          end
          if (free_count_q < cnt_t'(Capacity)) begin
            fs_we        = 1'b1;
            free_count_d = free_count_q + cnt_t'(1);
          end
          res_d   = StatDone;
          state_d = StResp;
        end else if (idx_inc == count_q) begin
          res_d   = StatNone;
          state_d = StResp;
        end else begin
          idx_d   = idx_inc;
          cur_d   = rd.next;
          rd_addr = rd.next;
        end
      end

      StDump: begin
        if (out_free) begin
          emit              = 1'b1;
          emit_item.status  = StatElem;
          emit_item.key_out = PortKeyBits'(rd.key);
          emit_item.last    = (idx_inc == count_q);
          if (idx_inc == count_q) begin
            state_d = StIdle;
          end else begin
            idx_d   = idx_inc;
            cur_d   = rd.next;
            rd_addr = rd.next;
          end
        end
      end

      StResp: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_item.status = res_q;
          emit_item.last   = 1'b1;
          state_d          = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      free_count_q <= cnt_t'(Capacity);
      low_mark_q   <= cnt_t'(Capacity);
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      free_count_q <= free_count_d;
      low_mark_q   <= low_mark_d;
      idx_q        <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    key_q <= key_d;
    res_q <= res_d;
    if (emit) out_q <= emit_item;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: src/dll_store.sv
module dll_store (
  input  logic               clk_i,
  input  dll_pkg::store_wr_t wr_i,
  input  dll_pkg::slot_t     raddr_i,
  output dll_pkg::store_rd_t rd_o
);
  import dll_pkg::*;

  key_t  key_mem  [Capacity];
  slot_t next_mem [Capacity];
  slot_t prev_mem [Capacity];

  store_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.key_we) key_mem[wr_i.key_addr] <= wr_i.key_data;
    if (wr_i.next_we) next_mem[wr_i.next_addr] <= wr_i.next_data;
    if (wr_i.prev_we) prev_mem[wr_i.prev_addr] <= wr_i.prev_data;
    rd_q.key  <= key_mem[raddr_i];
    rd_q.next <= next_mem[raddr_i];
    rd_q.prev <= prev_mem[raddr_i];
  end

  assign rd_o = rd_q;

endmodule

// File: tb/tb_doubly_linked_list_engine.sv
module tb_doubly_linked_list_engine;
  import dll_pkg::*;

  // kinds the block drops without an answer
  localparam logic [KindBits-1:0] KindSpareLo  = 3'd5;
  localparam logic [KindBits-1:0] KindSpareMid = 3'd6;
  localparam logic [KindBits-1:0] KindSpareHi  = 3'd7;

  localparam int RandomOps     = 100;
  localparam int SegmentLen    = 30;
  localparam int LongHold      = 300;
  localparam int DrainCycles   = 80;
  localparam int WatchdogLimit = 2000;
  localparam int DirectedRows  = 22;

  localparam int BiasGrow   = 0;
  localparam int BiasShrink = 1;

  typedef struct packed {
    logic [KindBits-1:0]           kind;
    logic signed [PortKeyBits-1:0] key;
    logic                          typed;
    status_e                       st;
  } op_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_o;

  key_t      list_keys[$];
  out_item_t answers[$];
  op_row_t   directed_ops[DirectedRows];
  int        failures;
  int        results_seen;
  int        idle_cycles;
  bit        calm;

  doubly_linked_list_engine uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void queue_answer(input status_e st, input key_t key, input logic fin);
    out_item_t a;
    a.status  = st;
    a.key_out = key;
    a.last    = fin;
    answers.push_back(a);
  endfunction

  // list held as a plain queue, front first
  function automatic void apply_list_op(input in_item_t op);
    int hit;
    hit = -1;
    case (op.kind)
      KindInsert: begin
        if (list_keys.size() >= Capacity) begin
          queue_answer(StatFull, '0, 1'b1);
        end else begin
          list_keys.push_front(op.key_in);
          queue_answer(StatDone, '0, 1'b1);
        end
      end
      KindDelKey: begin
        foreach (list_keys[i]) begin
          if (hit < 0 && list_keys[i] == op.key_in) hit = i;
        end
        if (hit >= 0) begin
          list_keys.delete(hit);
          queue_answer(StatDone, '0, 1'b1);
        end else begin
          queue_answer(StatNone, '0, 1'b1);
        end
      end
      KindDelFirst, KindDelLast: begin
        if (list_keys.size() == 0) begin
          queue_answer(StatNone, '0, 1'b1);
        end else begin
          if (op.kind == KindDelFirst) void'(list_keys.pop_front());
          else void'(list_keys.pop_back());
          queue_answer(StatDone, '0, 1'b1);
        end
      end
      KindDump: begin
        if (list_keys.size() == 0) begin
          queue_answer(StatNone, '0, 1'b1);
        end else begin
          foreach (list_keys[i]) queue_answer(StatElem, list_keys[i], i == list_keys.size() - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t make_random_op(input int bias);
    in_item_t op;
    int r;
    int cut_ins, cut_dk, cut_df, cut_dl;
    case (bias)
      BiasGrow:   begin cut_ins = 59; cut_dk = 74; cut_df = 82; cut_dl = 90; end
      BiasShrink: begin cut_ins = 19; cut_dk = 49; cut_df = 69; cut_dl = 89; end
      default:    begin cut_ins = 34; cut_dk = 59; cut_df = 74; cut_dl = 89; end
    endcase
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) op.key_in = $urandom();
    else op.key_in = int'($urandom_range(0, 8)) - 4;
    if (r < 4) op.kind = KindBits'($urandom_range(KindSpareLo, KindSpareHi));
    else if (r < cut_ins) op.kind = KindInsert;
    else if (r < cut_dk) op.kind = KindDelKey;
    else if (r < cut_df) op.kind = KindDelFirst;
    else if (r < cut_dl) op.kind = KindDelLast;
    else op.kind = KindDump;
    // mostly delete keys that are really in the list
    if (op.kind == KindDelKey && list_keys.size() != 0 && $urandom_range(0, 9) < 7)
      op.key_in = list_keys[$urandom_range(0, list_keys.size() - 1)];
    return op;
  endfunction

  // typed rows replace the predicted answer with the one written in the table
  task automatic offer_item(input in_item_t op, input logic typed, input status_e st);
    int gap;
    int n;
    gap = calm ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= op;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n = answers.size();
    apply_list_op(op);
    if (typed) begin
      while (answers.size() > n) void'(answers.pop_back());
      if (op.kind <= KindDump) queue_answer(st, '0, 1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (answers.size() == 0) begin
        failures++;
        $display("%0t: unexpected item status=%0d key=%0d last=%0d", $time,
                 out_o.status, out_o.key_out, out_o.last);
      end else begin
        want = answers.pop_front();
        if (out_o.status !== want.status) begin
          failures++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_o.status);
        end
        if (out_o.key_out !== want.key_out) begin
          failures++;
          $display("%0t: key_out expected %0d actual %0d", $time, want.key_out, out_o.key_out);
        end
        if (out_o.last !== want.last) begin
          failures++;
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_o.last);
        end
      end
    end
  end

  // counts cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("doubly_linked_list_engine test failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int stretch;
    bit held_long;
    held_long = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      // one long hold so the block backs up into its input
      if (!held_long && results_seen >= 40) begin
        held_long = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 9) == 0) stretch = $urandom_range(40, 120);
      else stretch = $urandom_range(1, 6);
      repeat (stretch) @(posedge clk_i);
      stretch = pick_idle();
      if (stretch > 0) begin
        out_ready_i <= 1'b0;
        repeat (stretch) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    in_item_t op;
    int real_ops;
    int seg;
    failures     = 0;
    results_seen = 0;
    idle_cycles  = 0;
    calm         = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_i         = '0;
    out_ready_i  = 1'b0;

    directed_ops = '{
      '{KindDump,     32'sd0,          1'b1, StatNone},
      '{KindDelFirst, 32'sd0,          1'b1, StatNone},
      '{KindDelLast,  32'sd0,          1'b1, StatNone},
      '{KindDelKey,   32'sd0,          1'b1, StatNone},
      '{KindSpareLo,  32'shffffffff,   1'b1, StatDone},
      '{KindInsert,   32'sh7fffffff,   1'b1, StatDone},
      '{KindInsert,   32'sh80000000,   1'b1, StatDone},
      '{KindInsert,   32'sd0,          1'b1, StatDone},
      '{KindInsert,   32'shffffffff,   1'b1, StatDone},
      '{KindInsert,   32'sh7fffffff,   1'b1, StatDone},
      '{KindDump,     32'sd0,          1'b0, StatDone},
      '{KindDelKey,   32'sd12345,      1'b1, StatNone},
      '{KindDelKey,   32'sh7fffffff,   1'b1, StatDone},
      '{KindDump,     32'sd0,          1'b0, StatDone},
      '{KindDelFirst, 32'sh55555555,   1'b1, StatDone},
      '{KindDelLast,  32'shaaaaaaaa,   1'b1, StatDone},
      '{KindSpareMid, 32'sh7fffffff,   1'b1, StatDone},
      '{KindSpareHi,  32'sh80000000,   1'b1, StatDone},
      '{KindDump,     32'sd0,          1'b0, StatDone},
      '{KindDelKey,   32'sh80000000,   1'b1, StatDone},
      '{KindDelFirst, 32'sd0,          1'b1, StatDone},
      '{KindDump,     32'sd0,          1'b1, StatNone}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[i]) begin
      op.kind   = directed_ops[i].kind;
      op.key_in = directed_ops[i].key;
      offer_item(op, directed_ops[i].typed, directed_ops[i].st);
    end

    // fill to capacity, overflow once, read the full list back
    while (list_keys.size() < Capacity) begin
      op.kind   = KindInsert;
      op.key_in = $urandom();
      offer_item(op, 1'b0, StatDone);
    end
    op.kind   = KindInsert;
    op.key_in = $urandom();
    offer_item(op, 1'b1, StatFull);
    op.kind = KindDump;
    offer_item(op, 1'b0, StatDone);

    real_ops = 0;
    seg      = 0;
    while (real_ops < RandomOps) begin
      calm = (seg % 4 == 3);
      repeat (SegmentLen) begin
        op = make_random_op(seg % 3);
        offer_item(op, 1'b0, StatDone);
        if (op.kind <= KindDump) real_ops++;
      end
      seg++;
    end
    in_valid_i <= 1'b0;

    while (answers.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("doubly_linked_list_engine test passed");
    end else begin
      $display("doubly_linked_list_engine test failed");
    end
    $finish;
  end

endmodule
